// ===== rtl/spkt_pkg.sv =====
// Shared types, operation codes and saturation helpers for the seam position tracker.
// Used by spkt_ctrl, spkt_dp, spkt_div and the top level; no dependencies.
package spkt_pkg;

    localparam int QW      = 32;   // Q16.16 word
    localparam int TW      = 24;   // Q8.16 time
    localparam int MW      = 33;   // multiplier operand width (signed)
    localparam int PW      = 66;   // product width
    localparam int RW      = 50;   // rounded product width kept
    localparam int SW      = 51;   // sum width ahead of saturation
    localparam int KW      = 17;   // gain width, Q1.16 up to 1.0
    localparam int NUMW    = 49;   // divider numerator
    localparam int DENW    = 33;   // divider denominator
    localparam int IDXW    = 2;

    localparam logic [KW-1:0]     KOne      = 17'd65536;
    localparam logic [MW-1:0]     Alpha     = 33'd19661;
    localparam logic [MW-1:0]     Beta      = 33'd45875;
    localparam logic [QW-1:0]     VarInit   = 32'd65536;
    localparam logic signed [PW-1:0] RndHalf = 66'sd32768;

    localparam logic [IDXW-1:0] CfgProcNoise = 2'd0;
    localparam logic [IDXW-1:0] CfgMeasNoise = 2'd1;
    localparam logic [IDXW-1:0] CfgLookahead = 2'd2;

    // multiplier operand selection
    localparam logic [2:0] MUL_DTDT = 3'd0;
    localparam logic [2:0] MUL_PNQ  = 3'd1;
    localparam logic [2:0] MUL_VDT  = 3'd2;
    localparam logic [2:0] MUL_KD   = 3'd3;
    localparam logic [2:0] MUL_AD   = 3'd4;
    localparam logic [2:0] MUL_BV   = 3'd5;
    localparam logic [2:0] MUL_VK   = 3'd6;
    localparam logic [2:0] MUL_VLA  = 3'd7;

    // write-back actions
    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_T    = 4'd1;
    localparam logic [3:0] WB_VARQ = 4'd2;
    localparam logic [3:0] WB_POS  = 4'd3;
    localparam logic [3:0] WB_DIFF = 4'd4;
    localparam logic [3:0] WB_K    = 4'd5;
    localparam logic [3:0] WB_ACC  = 4'd6;
    localparam logic [3:0] WB_VEL  = 4'd7;
    localparam logic [3:0] WB_VAR  = 4'd8;
    localparam logic [3:0] WB_PRED = 4'd9;
    localparam logic [3:0] WB_INIT = 4'd10;

    typedef struct packed {
        logic [2:0] mul_sel;
        logic [3:0] wb_sel;
        logic       axis;
        logic       load_in;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic meas_valid;
        logic div_busy;
        logic out_free;
    } status_t;

    function automatic logic [QW-1:0] sat32(input logic [SW-1:0] v);
        if ((v[SW-1:QW-1] == '0) || (v[SW-1:QW-1] == '1)) begin
            return v[QW-1:0];
        end
        return v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [QW-1:0] satu32(input logic [SW-1:0] v);
        if (v[SW-1:QW] != '0) begin
            return 32'hFFFF_FFFF;
        end
        return v[QW-1:0];
    endfunction

endpackage

// ===== rtl/seam_position_kalman_tracker_top.sv =====
// Seam position tracker top: 2-axis constant-velocity Kalman filter, Q16.16.
// Depends on spkt_pkg, spkt_ctrl, spkt_dp (which holds spkt_div).
//
//  channel  ports                                   handshake
//  input    s_elapsed_time s_meas_x/z s_meas_valid  s_valid / s_ready
//  result   m_est_x/z m_est_vx/vz m_pred_x/z        m_valid / m_ready
//           m_is_tracking
//  config   cfg_index cfg_wdata                     cfg_we, no wait
//
// One item at a time; each gain waits on the divider, the rest is the shared multiplier.
// Reset is synchronous, active low; no clearing pass.
// A result waiting on m_ready does not block acceptance of the next item; that item
// stalls in its output step until the waiting result is taken.
module seam_position_kalman_tracker_top
    import spkt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [IDXW-1:0]      cfg_index,
    input  logic [QW-1:0]        cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TW-1:0]        s_elapsed_time,
    input  logic signed [QW-1:0] s_meas_x,
    input  logic signed [QW-1:0] s_meas_z,
    input  logic                 s_meas_valid,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [QW-1:0] m_est_x,
    output logic signed [QW-1:0] m_est_z,
    output logic signed [QW-1:0] m_est_vx,
    output logic signed [QW-1:0] m_est_vz,
    output logic signed [QW-1:0] m_pred_x,
    output logic signed [QW-1:0] m_pred_z,
    output logic                 m_is_tracking
);

    cmd_t    cmd;
    status_t status;

    spkt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    spkt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_elapsed_time (s_elapsed_time),
        .s_meas_x       (s_meas_x),
        .s_meas_z       (s_meas_z),
        .s_meas_valid   (s_meas_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_est_x        (m_est_x),
        .m_est_z        (m_est_z),
        .m_est_vx       (m_est_vx),
        .m_est_vz       (m_est_vz),
        .m_pred_x       (m_pred_x),
        .m_pred_z       (m_pred_z),
        .m_is_tracking  (m_is_tracking)
    );

endmodule

// ===== rtl/spkt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// Depends on spkt_pkg; quotient is known to fit 17 bits (numerator < den * 2^17).
module spkt_div
    import spkt_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            busy,
    output logic [KW-1:0]   quot
);

    logic [DENW-1:0] rem_reg, rem_next;
    logic [DENW-1:0] den_reg;
    logic [KW-1:0]   low_reg, quot_reg;
    logic [4:0]      cnt_reg, cnt_next;
    logic [DENW+1:0] diff;

    assign diff = {1'b0, rem_reg, low_reg[KW-1]} - {2'b00, den_reg};

    always_comb begin
        rem_next = diff[DENW+1] ? {rem_reg[DENW-2:0], low_reg[KW-1]} : diff[DENW-1:0];
        cnt_next = cnt_reg - 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 5'(KW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num[NUMW-1:KW]};
            low_reg <= num[KW-1:0];
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[KW-2:0], 1'b0};
            quot_reg <= {quot_reg[KW-2:0], ~diff[DENW+1]};
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

// ===== rtl/spkt_dp.sv =====
// Datapath: filter state, config registers, shared 33x33 multiplier, output registers.
// Depends on spkt_pkg and spkt_div; driven by spkt_ctrl commands.
module spkt_dp
    import spkt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [IDXW-1:0]       cfg_index,
    input  logic [QW-1:0]         cfg_wdata,
    input  logic [TW-1:0]         s_elapsed_time,
    input  logic signed [QW-1:0]  s_meas_x,
    input  logic signed [QW-1:0]  s_meas_z,
    input  logic                  s_meas_valid,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [QW-1:0]  m_est_x,
    output logic signed [QW-1:0]  m_est_z,
    output logic signed [QW-1:0]  m_est_vx,
    output logic signed [QW-1:0]  m_est_vz,
    output logic signed [QW-1:0]  m_pred_x,
    output logic signed [QW-1:0]  m_pred_z,
    output logic                  m_is_tracking
);

    logic [QW-1:0] pn_reg, r_reg;
    logic [TW-1:0] la_reg;
    logic [TW-1:0] dt_reg;
    logic [QW-1:0] mx_reg, mz_reg;
    logic          mv_reg;
    logic [QW-1:0] pos_x_reg, pos_z_reg, vel_x_reg, vel_z_reg, var_x_reg, var_z_reg;
    logic          started_reg;
    logic [QW-1:0] pred_x_reg, pred_z_reg;
    logic [MW-1:0] t_reg, d_reg;
    logic [KW-1:0] k_reg;
    logic          den_zero_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;
    logic          m_valid_reg;
    logic [QW-1:0] o_ex_reg, o_ez_reg, o_vx_reg, o_vz_reg, o_px_reg, o_pz_reg;
    logic          o_trk_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic [QW-1:0]  pos_sel, vel_sel, var_sel, meas_sel;
    logic signed [PW-1:0] rnd_full, vel_full;
    logic [RW-1:0]  rnd;
    logic [SW-1:0]  pos_sum, varq_x, varq_z;
    logic [DENW-1:0] den;
    logic [NUMW-1:0] num;
    logic           div_start, div_busy;
    logic [KW-1:0]  div_quot;
    logic [QW-1:0]  pos_new, vel_new, var_new;

    assign pos_sel  = cmd.axis ? pos_z_reg : pos_x_reg;
    assign vel_sel  = cmd.axis ? vel_z_reg : vel_x_reg;
    assign var_sel  = cmd.axis ? var_z_reg : var_x_reg;
    assign meas_sel = cmd.axis ? mz_reg : mx_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_DTDT: begin
                mul_a = {9'd0, dt_reg};
                mul_b = {9'd0, dt_reg};
            end
            MUL_PNQ: begin
                mul_a = {1'b0, pn_reg};
                mul_b = t_reg;
            end
            MUL_VDT: begin
                mul_a = {vel_sel[QW-1], vel_sel};
                mul_b = {9'd0, dt_reg};
            end
            MUL_KD: begin
                mul_a = {16'd0, k_reg};
                mul_b = d_reg;
            end
            MUL_AD: begin
                mul_a = Alpha;
                mul_b = d_reg;
            end
            MUL_BV: begin
                mul_a = Beta;
                mul_b = {vel_sel[QW-1], vel_sel};
            end
            MUL_VK: begin
                mul_a = {1'b0, var_sel};
                mul_b = {16'd0, KOne - k_reg};
            end
            MUL_VLA: begin
                mul_a = {vel_sel[QW-1], vel_sel};
                mul_b = {9'd0, la_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd_full = (prod_reg + RndHalf) >>> 16;
    assign rnd      = rnd_full[RW-1:0];
    assign vel_full = (acc_reg + prod_reg) >>> 16;
    assign pos_sum  = {{(SW-QW){pos_sel[QW-1]}}, pos_sel} + {rnd[RW-1], rnd};
    assign varq_x   = {{(SW-QW){1'b0}}, var_x_reg} + {1'b0, rnd};
    assign varq_z   = {{(SW-QW){1'b0}}, var_z_reg} + {1'b0, rnd};
    assign pos_new  = sat32(pos_sum);
    assign vel_new  = sat32(vel_full[SW-1:0]);
    assign var_new  = satu32({1'b0, rnd});
    assign den      = {1'b0, var_sel} + {1'b0, r_reg};
    assign num      = {1'b0, var_sel, 16'd0} + {17'd0, den[DENW-1:1]};
    assign div_start = (cmd.wb_sel == WB_DIFF);

    spkt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg <= 32'd65536;
            r_reg  <= 32'd65536;
            la_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgProcNoise: pn_reg <= cfg_wdata;
                CfgMeasNoise: r_reg  <= cfg_wdata;
                CfgLookahead: la_reg <= cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load_in) begin
            dt_reg <= s_elapsed_time;
            mx_reg <= s_meas_x;
            mz_reg <= s_meas_z;
            mv_reg <= s_meas_valid;
        end
        case (cmd.wb_sel)
            WB_T:    t_reg <= rnd[MW-1:0];
            WB_DIFF: begin
                d_reg        <= {meas_sel[QW-1], meas_sel} - {pos_sel[QW-1], pos_sel};
                den_zero_reg <= (den == '0);
            end
            WB_K:    k_reg <= den_zero_reg ? '0 : ((div_quot > KOne) ? KOne : div_quot);
            WB_ACC:  acc_reg <= prod_reg + RndHalf;
            WB_PRED: begin
                if (cmd.axis) pred_z_reg <= pos_new;
                else          pred_x_reg <= pos_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_z_reg   <= '0;
            vel_x_reg   <= '0;
            vel_z_reg   <= '0;
            var_x_reg   <= VarInit;
            var_z_reg   <= VarInit;
            started_reg <= 1'b0;
        end else begin
            case (cmd.wb_sel)
                WB_VARQ: begin
                    var_x_reg <= satu32(varq_x);
                    var_z_reg <= satu32(varq_z);
                end
                WB_POS: begin
                    if (cmd.axis) pos_z_reg <= pos_new;
                    else          pos_x_reg <= pos_new;
                end
                WB_VEL: begin
                    if (cmd.axis) vel_z_reg <= vel_new;
                    else          vel_x_reg <= vel_new;
                end
                WB_VAR: begin
                    if (cmd.axis) var_z_reg <= var_new;
                    else          var_x_reg <= var_new;
                end
                WB_INIT: begin
                    pos_x_reg   <= mx_reg;
                    pos_z_reg   <= mz_reg;
                    vel_x_reg   <= '0;
                    vel_z_reg   <= '0;
                    var_x_reg   <= VarInit;
                    var_z_reg   <= VarInit;
                    started_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_ex_reg  <= pos_x_reg;
            o_ez_reg  <= pos_z_reg;
            o_vx_reg  <= vel_x_reg;
            o_vz_reg  <= vel_z_reg;
            o_px_reg  <= pred_x_reg;
            o_pz_reg  <= pred_z_reg;
            o_trk_reg <= started_reg;
        end
    end

    assign status.started    = started_reg;
    assign status.meas_valid = mv_reg;
    assign status.div_busy   = div_busy;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_est_x       = o_ex_reg;
    assign m_est_z       = o_ez_reg;
    assign m_est_vx      = o_vx_reg;
    assign m_est_vz      = o_vz_reg;
    assign m_pred_x      = o_px_reg;
    assign m_pred_z      = o_pz_reg;
    assign m_is_tracking = o_trk_reg;

endmodule

// ===== rtl/spkt_ctrl.sv =====
// Controller: sequences predict, correct and lookahead steps over the shared datapath.
// Depends on spkt_pkg; talks to spkt_dp through cmd_t / status_t.
module spkt_ctrl
    import spkt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DT2  = 4'd1;
    localparam logic [3:0] ST_QV   = 4'd2;
    localparam logic [3:0] ST_PPOS = 4'd3;
    localparam logic [3:0] ST_SEL  = 4'd4;
    localparam logic [3:0] ST_INIT = 4'd5;
    localparam logic [3:0] ST_DIFF = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_KPOS = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_VEL  = 4'd10;
    localparam logic [3:0] ST_VAR  = 4'd11;
    localparam logic [3:0] ST_PRED = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       phase_reg, phase_next;
    logic       axis_reg, axis_next;

    // two_phase steps: multiply, then write back
    function automatic logic two_phase(input logic [3:0] st);
        case (st)
            ST_DT2, ST_QV, ST_PPOS, ST_KPOS, ST_ACC, ST_VEL, ST_VAR, ST_PRED: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        phase_next   = two_phase(state_reg) ? ~phase_reg : 1'b0;
        cmd          = '0;
        cmd.axis     = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = status.started ? ST_DT2 : ST_SEL;
                end
            end
            ST_DT2: begin
                cmd.mul_sel = MUL_DTDT;
                if (phase_reg) begin
                    cmd.wb_sel = WB_T;
                    state_next = ST_QV;
                end
            end
            ST_QV: begin
                cmd.mul_sel = MUL_PNQ;
                if (phase_reg) begin
                    cmd.wb_sel = WB_VARQ;
                    state_next = ST_PPOS;
                end
            end
            ST_PPOS: begin
                cmd.mul_sel = MUL_VDT;
                if (phase_reg) begin
                    cmd.wb_sel = WB_POS;
                    axis_next  = ~axis_reg;
                    if (axis_reg) state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                if (!status.meas_valid) state_next = ST_PRED;
                else if (!status.started) state_next = ST_INIT;
                else state_next = ST_DIFF;
            end
            ST_INIT: begin
                cmd.wb_sel = WB_INIT;
                state_next = ST_PRED;
            end
            ST_DIFF: begin
                cmd.wb_sel = WB_DIFF;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    cmd.wb_sel = WB_K;
                    state_next = ST_KPOS;
                end
            end
            ST_KPOS: begin
                cmd.mul_sel = MUL_KD;
                if (phase_reg) begin
                    cmd.wb_sel = WB_POS;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.mul_sel = MUL_AD;
                if (phase_reg) begin
                    cmd.wb_sel = WB_ACC;
                    state_next = ST_VEL;
                end
            end
            ST_VEL: begin
                cmd.mul_sel = MUL_BV;
                if (phase_reg) begin
                    cmd.wb_sel = WB_VEL;
                    state_next = ST_VAR;
                end
            end
            ST_VAR: begin
                cmd.mul_sel = MUL_VK;
                if (phase_reg) begin
                    cmd.wb_sel = WB_VAR;
                    axis_next  = ~axis_reg;
                    state_next = axis_reg ? ST_PRED : ST_DIFF;
                end
            end
            ST_PRED: begin
                cmd.mul_sel = MUL_VLA;
                if (phase_reg) begin
                    cmd.wb_sel = WB_PRED;
                    axis_next  = ~axis_reg;
                    if (axis_reg) state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                axis_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while controller stays idle");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result overwrites an item not yet taken");
    a_start_once: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(status.started) |-> $past(cmd.wb_sel == WB_INIT))
        else $error("tracking started without an init step");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb_sel == WB_DIFF |=> status.div_busy)
        else $error("divider did not start");
`endif

endmodule

// ===== tb/sv/spkt_checker.sv =====
// Checker for the seam position tracker: watches the item and result channels,
// predicts each result with a fixed-point Kalman model and compares it field by field.
// Depends on spkt_pkg for widths and register indexes.
module spkt_checker
    import spkt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [IDXW-1:0]      cfg_index,
    input  logic [QW-1:0]        cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [TW-1:0]        s_elapsed_time,
    input  logic signed [QW-1:0] s_meas_x,
    input  logic signed [QW-1:0] s_meas_z,
    input  logic                 s_meas_valid,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [QW-1:0] m_est_x,
    input  logic signed [QW-1:0] m_est_z,
    input  logic signed [QW-1:0] m_est_vx,
    input  logic signed [QW-1:0] m_est_vz,
    input  logic signed [QW-1:0] m_pred_x,
    input  logic signed [QW-1:0] m_pred_z,
    input  logic                 m_is_tracking,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic signed [31:0] ex, ez, vx, vz, px, pz;
        logic               trk;
    } estimate_t;

    estimate_t estimates[$];

    logic [31:0] q_noise, r_noise;
    logic [23:0] horizon;
    logic signed [31:0] px_s, pz_s, vx_s, vz_s;
    logic [31:0] varx_s, varz_s;
    logic tracking;

    assign pending = estimates.size();

    function automatic longint rnd16(longint v);
        longint t;
        t = v + 32768;
        if (t >= 0) return t >>> 16;
        return -(((-t) + 65535) >>> 16);
    endfunction

    function automatic logic signed [31:0] clip_s(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] clip_u(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic signed [31:0] advance(logic signed [31:0] p,
                                                    logic signed [31:0] v, logic [23:0] t);
        longint prod;
        prod = longint'(v) * longint'({40'd0, t});
        return clip_s(longint'(p) + rnd16(prod));
    endfunction

    task automatic correct(inout logic signed [31:0] p, inout logic signed [31:0] v,
                           inout logic [31:0] var_q, input logic signed [31:0] meas);
        longint d;
        logic [63:0] den, k;
        d = longint'(meas) - longint'(p);
        den = {32'd0, var_q} + {32'd0, r_noise};
        k = 0;
        if (den != 0) k = (({32'd0, var_q} << 16) + (den >> 1)) / den;
        if (k > 65536) k = 65536;
        p = clip_s(longint'(p) + rnd16(longint'(k) * d));
        v = clip_s(rnd16(64'sd19661 * d + 64'sd45875 * longint'(v)));
        var_q = clip_u(({32'd0, var_q} * (64'd65536 - k) + 64'd32768) >> 16);
    endtask

    task automatic track_step(input logic [23:0] dt, input logic signed [31:0] mx,
                              input logic signed [31:0] mz, input logic mv);
        logic [63:0] dt2, qv;
        estimate_t e;
        if (tracking) begin
            dt2 = ({40'd0, dt} * {40'd0, dt} + 64'd32768) >> 16;
            qv = ({32'd0, q_noise} * dt2 + 64'd32768) >> 16;
            px_s = advance(px_s, vx_s, dt);
            pz_s = advance(pz_s, vz_s, dt);
            varx_s = clip_u({32'd0, varx_s} + qv);
            varz_s = clip_u({32'd0, varz_s} + qv);
        end
        if (mv) begin
            if (!tracking) begin
                px_s = mx; pz_s = mz; vx_s = 0; vz_s = 0;
                varx_s = 65536; varz_s = 65536; tracking = 1;
            end else begin
                correct(px_s, vx_s, varx_s, mx);
                correct(pz_s, vz_s, varz_s, mz);
            end
        end
        e.ex = px_s; e.ez = pz_s; e.vx = vx_s; e.vz = vz_s;
        e.px = advance(px_s, vx_s, horizon);
        e.pz = advance(pz_s, vz_s, horizon);
        e.trk = tracking;
        estimates.push_back(e);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        estimate_t w;
        if (!aresetn) begin
            q_noise <= 32'd65536; r_noise <= 32'd65536; horizon <= '0;
            px_s = 0; pz_s = 0; vx_s = 0; vz_s = 0;
            varx_s = 65536; varz_s = 65536; tracking = 0;
            estimates.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CfgProcNoise: q_noise <= cfg_wdata;
                    CfgMeasNoise: r_noise <= cfg_wdata;
                    CfgLookahead: horizon <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                track_step(s_elapsed_time, s_meas_x, s_meas_z, s_meas_valid);
            if (m_valid && m_ready) begin
                if (estimates.size() == 0) begin
                    report("unexpected item", 0, 0);
                end else begin
                    w = estimates.pop_front();
                    if (m_est_x !== w.ex) report("est_x", m_est_x, w.ex);
                    if (m_est_z !== w.ez) report("est_z", m_est_z, w.ez);
                    if (m_est_vx !== w.vx) report("est_vx", m_est_vx, w.vx);
                    if (m_est_vz !== w.vz) report("est_vz", m_est_vz, w.vz);
                    if (m_pred_x !== w.px) report("pred_x", m_pred_x, w.px);
                    if (m_pred_z !== w.pz) report("pred_z", m_pred_z, w.pz);
                    if (m_is_tracking !== w.trk) report("is_tracking", m_is_tracking, w.trk);
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the seam position tracker: clock, reset, register phases,
// directed and random frames with random idling; verdict from spkt_checker.
// Depends on spkt_pkg, seam_position_kalman_tracker_top and spkt_checker.
module tb;
    import spkt_pkg::*;

    logic aclk, aresetn;
    logic cfg_we;
    logic [IDXW-1:0] cfg_index;
    logic [QW-1:0] cfg_wdata;
    logic s_valid, s_ready;
    logic [TW-1:0] s_elapsed_time;
    logic signed [QW-1:0] s_meas_x, s_meas_z;
    logic s_meas_valid;
    logic m_valid, m_ready;
    logic signed [QW-1:0] m_est_x, m_est_z, m_est_vx, m_est_vz, m_pred_x, m_pred_z;
    logic m_is_tracking;
    int fail_count, pending;
    int cycles;
    logic calm;

    seam_position_kalman_tracker_top dut (.*);
    spkt_checker chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side stalls in bursts
    initial begin
        int n;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [31:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    // valid stays up after acceptance only until the next frame or drain drops it
    task automatic send_frame(input logic [23:0] dt, input logic signed [31:0] mx,
                              input logic signed [31:0] mz, input logic mv);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1; s_elapsed_time <= dt; s_meas_x <= mx; s_meas_z <= mz;
        s_meas_valid <= mv;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {$urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000} + $urandom_range(0, 65535);
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic [23:0] pick_dt();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 24'hFFFFFF;
            default: return $urandom_range(0, 8000);
        endcase
    endfunction

    initial begin
        logic [31:0] bx, bz;
        calm = 0;
        aresetn = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
        s_valid = 0; s_elapsed_time = 0; s_meas_x = 0; s_meas_z = 0; s_meas_valid = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: frames before tracking, first fix, extremes
        send_frame(24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_frame(0, 0, 0, 0);
        send_frame(24'd655, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_frame(24'd655, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_frame(24'd655, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_frame(24'hFFFFFF, 0, 0, 0);
        send_frame(24'hFFFFFF, 0, 0, 0);
        send_frame(24'hFFFFFF, 32'h0001_0000, 32'hFFFF_0000, 1);
        send_frame(0, 32'h5555_5555, 32'hAAAA_AAAA, 1);
        send_frame(24'hAAAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1);
        send_frame(24'h555555, 0, 0, 1);
        drain();
        write_reg(CfgProcNoise, 32'hFFFF_FFFF);
        write_reg(CfgMeasNoise, 32'd0);
        write_reg(CfgLookahead, 32'h00FF_FFFF);
        write_reg(2'd3, 32'h1234_5678);
        send_frame(24'hFFFFFF, 32'h100, 32'h200, 1);
        send_frame(24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_frame(24'h000001, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_frame(24'h010000, 32'h1000, 32'h2000, 1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CfgProcNoise, 32'd0); write_reg(CfgMeasNoise, 32'd1);
                         write_reg(CfgLookahead, 32'd0); end
                5: begin write_reg(CfgProcNoise, 32'd65536); write_reg(CfgMeasNoise, 32'd65536);
                         write_reg(CfgLookahead, 32'd3277); calm = 1; end
                default: begin write_reg(CfgProcNoise, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
                         write_reg(CfgMeasNoise, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 20));
                         write_reg(CfgLookahead, $urandom); end
            endcase
            bx = pick_pos(); bz = pick_pos();
            for (int i = 0; i < 190; i++) begin
                if ($urandom_range(0, 9) < 8)
                    send_frame(pick_dt(), bx + $urandom_range(0, 40000) - 20000,
                               bz + $urandom_range(0, 40000) - 20000, 1);
                else
                    send_frame(pick_dt(), $urandom, $urandom, $urandom_range(0, 1));
                if ($urandom_range(0, 30) == 0) begin bx = pick_pos(); bz = pick_pos(); end
            end
            drain();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
